// File: design/spg_pkg.sv
// ----------------------------------------------------------------------------
// spg_pkg: shared types and constants of the step pulse generator
// Command codes, register indexes and field widths used by the core and the
// period clamp.
// ----------------------------------------------------------------------------
package spg_pkg;

  localparam int unsigned PERIOD_W   = 32;  // requested period field
  localparam int unsigned LIMIT_W    = 16;  // clamp limit registers
  localparam int unsigned HALF_W     = 15;  // half period / tick counter
  localparam int unsigned PCOUNT_W   = 32;  // pulse_count / pulses_left fields

  localparam logic [LIMIT_W-1:0] RESET_MIN_PERIOD = 16'd20;
  localparam logic [LIMIT_W-1:0] RESET_MAX_PERIOD = 16'd60000;

  // Command carried with each input transfer
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2
  } mode_e;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_MIN_PERIOD = 1'b0,
    REG_MAX_PERIOD = 1'b1
  } reg_idx_e;

endpackage

// File: design/step_pulse_generator_unit.sv
// ----------------------------------------------------------------------------
// step_pulse_generator_unit: step/direction pulse generator for a stepper
// Result: the status of an input transfer is registered and is on m_axis in the next cycle.
// Throughput: one input transfer per cycle; the single result register is
//   refilled in the same cycle it is drained, so only a stalled m_axis stops s_axis.
// Reset: move state, pins and result valid cleared; limits set to 20/60000 us.
// ----------------------------------------------------------------------------
module step_pulse_generator_unit
  import spg_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 32  // width of the pulse down-counter, 8..32
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,

  // Command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] direction, [32:1] pulse_count, [64:33] period_us, [71:65] zero
  input  logic [71:0] s_axis_tdata,
  // [1:0] mode
  input  logic [1:0]  s_axis_tuser,

  // Status stream, one transfer per command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] step_level, [1] dir_level, [2] busy_res, [34:3] pulses_left,
  // [35] move_done, [36] start_rejected, [39:37] zero
  output logic [39:0] m_axis_tdata
);

  // --------------------------------------------------------------------------
  // Configuration: limits are always writable, one write per cycle
  // --------------------------------------------------------------------------
  logic [LIMIT_W-1:0] min_period_q, max_period_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_period_q <= RESET_MIN_PERIOD;
      max_period_q <= RESET_MAX_PERIOD;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_MIN_PERIOD: min_period_q <= cfg_data_i;
        REG_MAX_PERIOD: max_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input unpacking
  // --------------------------------------------------------------------------
  mode_e               in_mode;
  logic                in_dir;
  logic [PCOUNT_W-1:0] in_count;
  logic [PERIOD_W-1:0] in_period;

  assign in_mode   = mode_e'(s_axis_tuser);
  assign in_dir    = s_axis_tdata[0];
  assign in_count  = s_axis_tdata[32:1];
  assign in_period = s_axis_tdata[64:33];

  // Output register stalls only when it holds data nobody is taking
  logic out_valid_q;
  logic in_xfer;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Start command: half period from the clamp, pulse count saturated to
  // the counter width
  // --------------------------------------------------------------------------
  logic [HALF_W-1:0]     start_half;
  logic [COUNT_BITS-1:0] start_count;

  spg_period_clamp u_clamp (
    .period_i      (in_period),
    .min_period_i  (min_period_q),
    .max_period_i  (max_period_q),
    .half_period_o (start_half)
  );

  if (COUNT_BITS < PCOUNT_W) begin : g_count_sat
    assign start_count = (|in_count[PCOUNT_W-1:COUNT_BITS]) ? '1
                                                              : in_count[COUNT_BITS-1:0];
  end else begin : g_count_full
    assign start_count = in_count[COUNT_BITS-1:0];
  end

  // --------------------------------------------------------------------------
  // Move state
  // --------------------------------------------------------------------------
  logic                  pin_q, pin_d;
  logic                  dir_q, dir_d;
  logic                  moving_q, moving_d;
  logic [COUNT_BITS-1:0] pulses_q, pulses_d;
  logic [HALF_W-1:0]     half_q, half_d;
  logic [HALF_W-1:0]     tick_q, tick_d;
  logic                  done_d, rejected_d;

  // Tick path helpers
  logic [HALF_W-1:0]     tick_inc;
  logic [HALF_W-1:0]     half_eff;
  logic [COUNT_BITS-1:0] pulses_dec;

  assign tick_inc   = tick_q + HALF_W'(1);   // wraps at 15 bits
  assign half_eff   = (half_q == '0) ? HALF_W'(1) : half_q;
  assign pulses_dec = (pulses_q != '0) ? pulses_q - COUNT_BITS'(1) : pulses_q;

  always_comb begin
    pin_d      = pin_q;
    dir_d      = dir_q;
    moving_d   = moving_q;
    pulses_d   = pulses_q;
    half_d     = half_q;
    tick_d     = tick_q;
    done_d     = 1'b0;
    rejected_d = 1'b0;

    unique case (in_mode)
      MODE_TICK: begin
        if (moving_q) begin
          tick_d = tick_inc;
          if (tick_inc >= half_eff) begin
            tick_d = '0;
            if (!pin_q) begin
              pin_d = 1'b1;
            end else begin
              // falling edge ends one pulse
              pin_d    = 1'b0;
              pulses_d = pulses_dec;
              if (pulses_dec == '0) begin
                moving_d = 1'b0;
                done_d   = 1'b1;
              end
            end
          end
        end
      end
      MODE_START: begin
        if (in_count == '0) begin
          rejected_d = 1'b1;   // running move is left alone
        end else begin
          pin_d    = 1'b0;
          tick_d   = '0;
          dir_d    = in_dir;
          pulses_d = start_count;
          half_d   = start_half;
          moving_d = 1'b1;
        end
      end
      MODE_STOP: begin
        // direction pin keeps its level
        pin_d    = 1'b0;
        moving_d = 1'b0;
        pulses_d = '0;
        half_d   = '0;
        tick_d   = '0;
      end
      default: ;   // unused code: report state only
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_q    <= 1'b0;
      dir_q    <= 1'b0;
      moving_q <= 1'b0;
      pulses_q <= '0;
      half_q   <= '0;
      tick_q   <= '0;
    end else if (in_xfer) begin
      pin_q    <= pin_d;
      dir_q    <= dir_d;
      moving_q <= moving_d;
      pulses_q <= pulses_d;
      half_q   <= half_d;
      tick_q   <= tick_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [39:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= {3'b000, rejected_d, done_d, PCOUNT_W'(pulses_d),
                     moving_d, dir_d, pin_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A running move always has pulses left to emit
  a_busy_has_pulses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    moving_q |-> (pulses_q != '0))
    else $error("move running with zero pulses left");

  // A running move always has a usable half period
  a_busy_has_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    moving_q |-> (half_q != '0))
    else $error("move running with zero half period");

  // Completion is reported only with the pin low and the move ended
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[35]) |-> (!out_data_q[2] && !out_data_q[0]))
    else $error("move_done reported while still busy or step high");

  // A rejected start leaves the move state untouched
  a_reject_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && rejected_d) |=> ($stable(moving_q) && $stable(pulses_q)))
    else $error("rejected start changed the move state");

endmodule

// File: design/spg_period_clamp.sv
// ----------------------------------------------------------------------------
// spg_period_clamp: period limit and half-period derivation
// Clamps the requested full period to [min, max] (max wins when the limits
// cross), halves it by truncation and never returns a half period of zero.
// ----------------------------------------------------------------------------
module spg_period_clamp
  import spg_pkg::*;
(
  input  logic [PERIOD_W-1:0] period_i,
  input  logic [LIMIT_W-1:0]  min_period_i,
  input  logic [LIMIT_W-1:0]  max_period_i,
  output logic [HALF_W-1:0]   half_period_o
);

  logic [PERIOD_W-1:0] lo_clamped;
  logic [LIMIT_W-1:0]  full_period;
  logic [HALF_W-1:0]   half_raw;

  always_comb begin
    if (period_i < PERIOD_W'(min_period_i)) begin
      lo_clamped = PERIOD_W'(min_period_i);
    end else begin
      lo_clamped = period_i;
    end
    if (lo_clamped > PERIOD_W'(max_period_i)) begin
      full_period = max_period_i;
    end else begin
      full_period = lo_clamped[LIMIT_W-1:0];
    end
    half_raw = full_period[LIMIT_W-1:1];
    half_period_o = (half_raw == '0) ? HALF_W'(1) : half_raw;
  end

endmodule

// File: tb/step_pulse_generator_unit_test.sv
// ----------------------------------------------------------------------------
// step_pulse_generator_unit_test: self-checking bench for the step pulse unit
// Drives tick/start/stop and unused-code commands on s_axis, writes the period limits
// between phases, and checks every status transfer on m_axis against a typed status
// or an in-bench model of the step/direction pins, the pulse counter and the period clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module step_pulse_generator_unit_test;
  import spg_pkg::*;

  localparam int unsigned CTR_W          = 32;      // pulse down-counter width
  localparam logic [63:0] CTR_MAX        = (64'd1 << CTR_W) - 64'd1;
  localparam logic [1:0]  MODE_NONE      = 2'd3;    // unused command code
  localparam int          IDLE_PCT       = 31;      // idle cycles per hundred
  localparam int          WATCHDOG_LIMIT = 2000;    // cycles with no transfer
  localparam int          TAIL_CYCLES    = 8;
  localparam int          REPORT_MAX     = 10;

  // One command as the block sees it
  typedef struct packed {
    logic [1:0]  mode;
    logic        dir;
    logic [31:0] count;
    logic [31:0] period;
  } cmd_t;

  // Status transfer, laid out as m_axis_tdata (step_level in bit 0)
  typedef struct packed {
    logic [2:0]  pad;
    logic        rejected;
    logic        done;
    logic [31:0] left;
    logic        busy;
    logic        dir;
    logic        step;
  } status_t;

  // Directed row: command plus, where typed is set, the status it must give
  typedef struct packed {
    logic [1:0]  mode;
    logic        dir;
    logic [31:0] count;
    logic [31:0] period;
    logic        typed;
    logic        w_step;
    logic        w_dir;
    logic        w_busy;
    logic [31:0] w_left;
    logic        w_done;
    logic        w_rej;
  } row_t;

  // All rows run with the reset limits (20 / 60000 us)
  localparam row_t DIRECTED_ROWS [20] = '{
    // idle block: tick, stop and the unused code change nothing
    '{MODE_TICK,  1'b0, 32'd0, 32'd0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
    '{MODE_STOP,  1'b1, 32'd9, 32'd9, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
    '{MODE_NONE,  1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
    // zero count rejected, direction untouched
    '{MODE_START, 1'b1, 32'd0, 32'd100, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b1},
    // period below the lower limit
    '{MODE_START, 1'b1, 32'd1, 32'd0, 1'b1, 1'b0, 1'b1, 1'b1, 32'd1, 1'b0, 1'b0},
    // zero count while moving: rejected, move goes on
    '{MODE_START, 1'b0, 32'd0, 32'd5, 1'b1, 1'b0, 1'b1, 1'b1, 32'd1, 1'b0, 1'b1},
    '{MODE_TICK,  1'b0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
    '{MODE_NONE,  1'b0, 32'd3, 32'd3, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
    // stop keeps the direction pin
    '{MODE_STOP,  1'b0, 32'd0, 32'd0, 1'b1, 1'b0, 1'b1, 1'b0, 32'd0, 1'b0, 1'b0},
    // all-ones count and period, period above the upper limit
    '{MODE_START, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        1'b1, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0},
    '{MODE_TICK,  1'b1, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
    // restart over a running move, just above the upper limit
    '{MODE_START, 1'b0, 32'h8000_0000, 32'd60001,
                        1'b1, 1'b0, 1'b0, 1'b1, 32'h8000_0000, 1'b0, 1'b0},
    '{MODE_START, 1'b1, 32'd7, 32'd21, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
    '{MODE_TICK,  1'b0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
    '{MODE_STOP,  1'b0, 32'd0, 32'd0, 1'b1, 1'b0, 1'b1, 1'b0, 32'd0, 1'b0, 1'b0},
    '{MODE_START, 1'b0, 32'd1, 32'd20, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
    '{MODE_TICK,  1'b1, 32'd5, 32'd5, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
    '{MODE_START, 1'b1, 32'd2, 32'd19, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
    '{MODE_STOP,  1'b0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
    '{MODE_TICK,  1'b0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0}
  };

  // Random phases: limits and command count per phase. Phase 0 keeps the
  // reset limits; the others cover two narrow windows, both limits at the
  // bottom, crossed limits, the full range and both limits at the top.
  localparam logic [15:0] PH_MIN   [7] = '{RESET_MIN_PERIOD, 16'd2, 16'd2, 16'd9,
                                           16'd2, 16'd65535, 16'd3};
  localparam logic [15:0] PH_MAX   [7] = '{RESET_MAX_PERIOD, 16'd12, 16'd2, 16'd4,
                                           16'd65535, 16'd65535, 16'd7};
  localparam int          PH_ITEMS [7] = '{150, 450, 350, 300, 400, 80, 200};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // [0] dir, [32:1] count, [64:33] period
  logic [1:0]  s_axis_tuser = '0;   // [1:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // status_t layout

  // Model state: pins, move, limits
  logic              step_q;
  logic              dir_q;
  logic              moving_q;
  logic [CTR_W-1:0]  pulses_q;
  logic [HALF_W-1:0] half_q;
  logic [HALF_W-1:0] tick_q;
  logic [15:0]       min_lim;
  logic [15:0]       max_lim;

  status_t pin_status_due [$];   // status transfers still to arrive
  status_t mon_got;
  status_t mon_want;
  int      mismatch_cnt = 0;
  int      quiet_cycles = 0;
  logic    steady = 1'b0;        // no idling on either side while set

  step_pulse_generator_unit #(
    .COUNT_BITS(CTR_W)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Apply one command to the model and return the status it leaves
  function automatic status_t apply_cmd(input cmd_t c);
    status_t           st;
    logic [HALF_W-1:0] hp;
    logic [63:0]       cnt;
    logic [31:0]       per;
    logic [31:0]       hp_w;
    st = '0;
    case (c.mode)
      MODE_TICK: begin
        if (moving_q) begin
          hp = (half_q == '0) ? HALF_W'(1) : half_q;
          tick_q = tick_q + HALF_W'(1);
          if (tick_q >= hp) begin
            tick_q = '0;
            if (!step_q) begin
              step_q = 1'b1;
            end else begin
              // falling edge ends one pulse
              step_q = 1'b0;
              if (pulses_q != '0) pulses_q = pulses_q - CTR_W'(1);
              if (pulses_q == '0) begin
                moving_q = 1'b0;
                st.done  = 1'b1;
              end
            end
          end
        end
      end
      MODE_START: begin
        if (c.count == '0) begin
          st.rejected = 1'b1;
        end else begin
          cnt = {32'd0, c.count};
          if (cnt > CTR_MAX) cnt = CTR_MAX;
          // lower limit first, so the upper one wins when they cross
          per = c.period;
          if (per < {16'd0, min_lim}) per = {16'd0, min_lim};
          if (per > {16'd0, max_lim}) per = {16'd0, max_lim};
          hp_w = per >> 1;
          if (hp_w == '0) hp_w = 32'd1;
          step_q   = 1'b0;
          tick_q   = '0;
          dir_q    = c.dir;
          pulses_q = cnt[CTR_W-1:0];
          half_q   = hp_w[HALF_W-1:0];
          moving_q = 1'b1;
        end
      end
      MODE_STOP: begin
        moving_q = 1'b0;
        step_q   = 1'b0;
        pulses_q = '0;
        half_q   = '0;
        tick_q   = '0;
      end
      default: ;
    endcase
    st.step = step_q;
    st.dir  = dir_q;
    st.busy = moving_q;
    st.left = 32'(pulses_q);
    return st;
  endfunction

  // Offer one command on s_axis; called and returning at a falling edge.
  // A typed status, when given, is expected instead of the model's.
  task automatic send_cmd(input cmd_t c, input logic typed, input status_t want);
    status_t st;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, c.period, c.count, c.dir};
    s_axis_tuser  <= c.mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    st = apply_cmd(c);
    pin_status_due.push_back(typed ? want : st);
    @(negedge clk_i);
  endtask

  // Hold the sender off until every status transfer is in
  task automatic drain_status();
    s_axis_tvalid <= 1'b0;
    while (pin_status_due.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // Write both limits; only called with nothing in flight
  task automatic set_limits(input logic [15:0] lo, input logic [15:0] hi);
    for (int k = 0; k < 2; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= (k == 0) ? REG_MIN_PERIOD : REG_MAX_PERIOD;
      cfg_data_i  <= (k == 0) ? lo : hi;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      if (k == 0) min_lim = lo;
      else        max_lim = hi;
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic flag_error(input string what, input status_t want, input status_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_MAX) begin
      $display("%0t: %s", $realtime, what);
      $display("  exp step=%0b dir=%0b busy=%0b left=%0d done=%0b rej=%0b",
               want.step, want.dir, want.busy, want.left, want.done, want.rejected);
      $display("  got step=%0b dir=%0b busy=%0b left=%0d done=%0b rej=%0b",
               got.step, got.dir, got.busy, got.left, got.done, got.rejected);
    end
  endtask

  // Receiver: stalls at random, at the IDLE_PCT rate, outside the steady stretch
  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Status check on every m_axis transfer
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      mon_got = status_t'(m_axis_tdata);
      if (pin_status_due.size() == 0) begin
        flag_error("status transfer with nothing expected", '0, mon_got);
      end else begin
        mon_want = pin_status_due.pop_front();
        if (mon_got.step !== mon_want.step || mon_got.dir !== mon_want.dir ||
            mon_got.busy !== mon_want.busy || mon_got.left !== mon_want.left ||
            mon_got.done !== mon_want.done || mon_got.rejected !== mon_want.rejected ||
            mon_got.pad !== mon_want.pad) begin
          flag_error("status mismatch", mon_want, mon_got);
        end
      end
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("step_pulse_generator_unit_test: done, errors");
        $finish;
      end
    end
  end

  initial begin : stim
    cmd_t    c;
    row_t    row;
    status_t typed_st;
    int      r;
    // reset values of the model
    step_q   = 1'b0;
    dir_q    = 1'b0;
    moving_q = 1'b0;
    pulses_q = '0;
    half_q   = '0;
    tick_q   = '0;
    min_lim  = RESET_MIN_PERIOD;
    max_lim  = RESET_MAX_PERIOD;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows
    foreach (DIRECTED_ROWS[i]) begin
      row      = DIRECTED_ROWS[i];
      c        = '{row.mode, row.dir, row.count, row.period};
      typed_st = '{3'd0, row.w_rej, row.w_done, row.w_left, row.w_busy, row.w_dir,
                   row.w_step};
      send_cmd(c, row.typed, typed_st);
    end

    // Random phases; each starts from a drained block so limits may change
    for (int p = 0; p < 7; p++) begin
      drain_status();
      if (p != 0) set_limits(PH_MIN[p], PH_MAX[p]);
      for (int k = 0; k < PH_ITEMS[p]; k++) begin
        steady   = (p == 1) && (k < 300);
        c.dir    = 1'($urandom);
        c.count  = $urandom;
        c.period = $urandom;
        r = $urandom_range(0, 99);
        if (r < 72) begin
          c.mode = MODE_TICK;          // data bits are don't-care noise
        end else if (r < 84) begin
          // well-formed start: short move, period mostly near the limits
          c.mode = MODE_START;
          if ($urandom_range(0, 99) < 85) c.count  = $urandom_range(1, 4);
          if ($urandom_range(0, 99) < 90) c.period = $urandom_range(0, 24);
        end else if (r < 88) begin
          c.mode  = MODE_START;
          c.count = '0;
        end else if (r < 94) begin
          c.mode = MODE_STOP;
        end else begin
          c.mode = MODE_NONE;
        end
        send_cmd(c, 1'b0, '0);
      end
      steady = 1'b0;
    end

    drain_status();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pin_status_due.size() != 0) begin
      mismatch_cnt += pin_status_due.size();
      $display("%0d status transfers never arrived", pin_status_due.size());
    end
    if (mismatch_cnt == 0) begin
      $display("step_pulse_generator_unit_test: done, clean");
    end else begin
      $display("step_pulse_generator_unit_test: done, errors");
    end
    $finish;
  end

endmodule
